// ===== sv/obd_response_decoder_core_macros.svh =====
// Assertion macros for the OBD response decoder.
`ifndef OBD_RESPONSE_DECODER_CORE_MACROS_SVH
`define OBD_RESPONSE_DECODER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define OBD_RD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("obd_rd: implication failed");
`define OBD_RD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("obd_rd: next-cycle implication failed");
`else
`define OBD_RD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define OBD_RD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/obd_rd_pkg.sv =====
// Shared types, character codes and helpers of the OBD response decoder.
package obd_rd_pkg;

    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_FOUR   = 8'h34;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_PROMPT = 8'h3E;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UF     = 8'h46;
    localparam logic [7:0] CH_V      = 8'h56;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LF_HEX = 8'h66;

    localparam logic [7:0] PID_LOAD    = 8'h04;
    localparam logic [7:0] PID_COOLANT = 8'h05;
    localparam logic [7:0] PID_RPM     = 8'h0C;
    localparam logic [7:0] PID_INTAKE  = 8'h0F;
    localparam logic [7:0] PID_MAF     = 8'h10;

    localparam logic [13:0] VOLT_MAX = 14'd9999;
    localparam int          VALUE_W  = 22;

    // floor(a*10000/255) == (a * round_up(2^30/255) * 10000) >> 30 for all 8-bit a
    localparam logic [35:0] LOAD_MUL   = 36'd42107530000;
    localparam int          LOAD_SHIFT = 30;

    typedef enum logic [2:0] {
        KIND_EMPTY,
        KIND_PID_DEC,
        KIND_DEC,
        KIND_PID,
        KIND_FRAC,
        KIND_VOLTS
    } line_kind_t;

    typedef enum logic [2:0] {
        QTY_COOLANT,
        QTY_INTAKE,
        QTY_RPM,
        QTY_LOAD,
        QTY_MAF,
        QTY_VOLTS
    } quantity_t;

    typedef struct packed {
        logic [3:0]  pos;
        line_kind_t  kind;
        logic [7:0]  pid;
        logic [7:0]  a;
        logic [7:0]  b;
        logic [13:0] volt;
        logic [1:0]  frac;
        logic        bad;
    } line_state_t;

    localparam line_state_t LINE_CLEAR = '{
        pos: 4'd0, kind: KIND_EMPTY, pid: 8'd0, a: 8'd0, b: 8'd0,
        volt: 14'd0, frac: 2'd0, bad: 1'b0
    };

    function automatic logic is_ignored(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_LF);
    endfunction

    function automatic logic is_term(input logic [7:0] c);
        return (c == CH_CR) || (c == CH_PROMPT);
    endfunction

    function automatic logic is_dec(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_dec(c) || ((c >= CH_UA) && (c <= CH_UF))
            || ((c >= CH_LA) && (c <= CH_LF_HEX));
    endfunction

    // Letters A-F and a-f both carry 1..6 in the low nibble.
    function automatic logic [3:0] hex_val(input logic [7:0] c);
        return is_dec(c) ? c[3:0] : 4'(c[3:0] + 4'd9);
    endfunction

endpackage

// ===== sv/obd_rd_parse.sv =====
// Line parser: holds the per-line state and advances it one character at a time.
module obd_rd_parse (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   take,
    input  logic [7:0]             ch,
    output obd_rd_pkg::line_state_t state
);
    import obd_rd_pkg::*;

    line_state_t state_reg;
    line_state_t state_next;
    line_state_t upd;
    logic        pid_ok;
    logic        vk_hit;
    line_kind_t  vk;
    logic [16:0] volt_sum;
    logic [3:0]  digit;
    logic        add_digit;
    logic [3:0]  nib;
    logic        kind_pid_side;
    logic        kind_volt_side;

    assign digit = ch[3:0];
    assign nib   = hex_val(ch);

    always_comb
    begin
        upd            = state_reg;
        pid_ok         = 1'b0;
        vk_hit         = 1'b0;
        vk             = KIND_EMPTY;
        add_digit      = 1'b0;
        kind_pid_side  = (state_reg.kind == KIND_EMPTY) || (state_reg.kind == KIND_PID_DEC)
                      || (state_reg.kind == KIND_PID);
        kind_volt_side = (state_reg.kind == KIND_EMPTY) || (state_reg.kind == KIND_PID_DEC)
                      || (state_reg.kind == KIND_DEC) || (state_reg.kind == KIND_FRAC);

        if (kind_pid_side)
        begin
            if (state_reg.pos >= 4'd8)
            begin
                pid_ok = 1'b1;
            end
            else if (state_reg.pos == 4'd0)
            begin
                pid_ok = (ch == CH_FOUR);
            end
            else if (state_reg.pos == 4'd1)
            begin
                pid_ok = (ch == CH_ONE);
            end
            else if (is_hex(ch))
            begin
                pid_ok = 1'b1;
                case (state_reg.pos[2:0])
                    3'd2:    upd.pid = {nib, 4'd0};
                    3'd3:    upd.pid = {state_reg.pid[7:4], nib};
                    3'd4:    upd.a   = {nib, 4'd0};
                    3'd5:    upd.a   = {state_reg.a[7:4], nib};
                    3'd6:    upd.b   = {nib, 4'd0};
                    default: upd.b   = {state_reg.b[7:4], nib};
                endcase
            end
        end

        if (kind_volt_side)
        begin
            if (is_dec(ch))
            begin
                vk_hit = 1'b1;
                if (state_reg.kind == KIND_FRAC)
                begin
                    vk = KIND_FRAC;
                    if (state_reg.frac < 2'd2)
                    begin
                        add_digit = 1'b1;
                        upd.frac  = 2'(state_reg.frac + 2'd1);
                    end
                end
                else
                begin
                    vk        = KIND_DEC;
                    add_digit = 1'b1;
                end
            end
            else if ((ch == CH_DOT) && (state_reg.kind != KIND_FRAC))
            begin
                vk_hit = 1'b1;
                vk     = KIND_FRAC;
            end
            else if ((ch == CH_V) && ((state_reg.kind == KIND_PID_DEC)
                     || (state_reg.kind == KIND_DEC)
                     || ((state_reg.kind == KIND_FRAC) && (state_reg.pos >= 4'd2))))
            begin
                vk_hit = 1'b1;
                vk     = KIND_VOLTS;
            end
        end

        volt_sum = 17'(state_reg.volt) * 17'd10 + 17'(digit);
        if (add_digit)
        begin
            upd.volt = (volt_sum > 17'(VOLT_MAX)) ? VOLT_MAX : volt_sum[13:0];
        end

        if (pid_ok && vk_hit && (vk == KIND_DEC))
        begin
            upd.kind = KIND_PID_DEC;
        end
        else if (pid_ok)
        begin
            upd.kind = KIND_PID;
        end
        else if (vk_hit)
        begin
            upd.kind = vk;
        end
        else
        begin
            upd.bad = 1'b1;
        end

        // a spoilt line keeps counting characters but nothing else
        if (state_reg.bad)
        begin
            upd = state_reg;
        end
        if (state_reg.pos != 4'd15)
        begin
            upd.pos = 4'(state_reg.pos + 4'd1);
        end

        state_next = state_reg;
        if (take)
        begin
            if (is_term(ch))
            begin
                state_next = LINE_CLEAR;
            end
            else if (!is_ignored(ch))
            begin
                state_next = upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= LINE_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign state = state_reg;

endmodule

// ===== sv/obd_rd_value.sv =====
// Value decoder: turns a finished line into a quantity code and a value in hundredths.
module obd_rd_value (
    input  obd_rd_pkg::line_state_t state,
    output logic                    ok,
    output obd_rd_pkg::quantity_t   qty,
    output logic signed [21:0]      val
);
    import obd_rd_pkg::*;

    logic signed [21:0] temp_val;
    logic [43:0]        load_prod;
    logic [20:0]        rpm_val;
    logic [19:0]        volt_scaled;
    logic [13:0]        volt_val;
    logic               pid_line;

    assign temp_val  = ($signed({14'd0, state.a}) - 22'sd40) * 22'sd100;
    assign load_prod = 44'(state.a) * 44'(LOAD_MUL);
    assign rpm_val   = 21'({state.a, state.b} >> 2) * 21'd100;
    assign pid_line  = ((state.kind == KIND_PID_DEC) || (state.kind == KIND_PID))
                    && (state.pos >= 4'd6);

    always_comb
    begin
        case (state.frac)
            2'd0:    volt_scaled = 20'(state.volt) * 20'd100;
            2'd1:    volt_scaled = 20'(state.volt) * 20'd10;
            default: volt_scaled = 20'(state.volt);
        endcase
        volt_val = (volt_scaled > 20'(VOLT_MAX)) ? VOLT_MAX : volt_scaled[13:0];
    end

    always_comb
    begin
        ok  = 1'b0;
        qty = QTY_COOLANT;
        val = temp_val;
        if (!state.bad && (state.pos != 4'd0))
        begin
            if (state.kind == KIND_VOLTS)
            begin
                ok  = 1'b1;
                qty = QTY_VOLTS;
                val = $signed(22'(volt_val));
            end
            else if (pid_line)
            begin
                unique case (state.pid)
                    PID_COOLANT:
                    begin
                        ok  = 1'b1;
                        qty = QTY_COOLANT;
                        val = temp_val;
                    end
                    PID_INTAKE:
                    begin
                        ok  = 1'b1;
                        qty = QTY_INTAKE;
                        val = temp_val;
                    end
                    PID_LOAD:
                    begin
                        ok  = 1'b1;
                        qty = QTY_LOAD;
                        val = $signed(22'(load_prod[43:LOAD_SHIFT]));
                    end
                    PID_RPM:
                    begin
                        ok  = (state.pos >= 4'd8);
                        qty = QTY_RPM;
                        val = $signed(22'(rpm_val));
                    end
                    PID_MAF:
                    begin
                        ok  = (state.pos >= 4'd8);
                        qty = QTY_MAF;
                        val = $signed(22'({state.a, state.b}));
                    end
                    default:
                    begin
                        ok = 1'b0;
                    end
                endcase
            end
        end
    end

endmodule

// ===== sv/obd_response_decoder_core.sv =====
// A line terminator's result passes from the character register into the result register.
// Throughput: one character request per cycle; only a terminator that yields a result
// waits, and only while the result register still holds an untaken result.
// The character register and result register part the two channels.
// Reset (rst_n low, asynchronous) empties both registers and clears the line state.
// Top level: character register, line parser, value decoder and result register.
`include "obd_response_decoder_core_macros.svh"
module obd_response_decoder_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_char,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  quantity,
    output logic signed [21:0] value
);
    import obd_rd_pkg::*;

    logic               in_valid_reg;
    logic               in_valid_next;
    logic [7:0]         rx_char_reg;
    logic [7:0]         rx_char_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [2:0]         quantity_reg;
    logic [2:0]         quantity_next;
    logic signed [21:0] value_reg;
    logic signed [21:0] value_next;

    line_state_t        line_state;
    logic               res_ok;
    quantity_t          res_qty;
    logic signed [21:0] res_val;
    logic               emit;
    logic               adv;

    obd_rd_parse u_parse (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (adv),
        .ch    (rx_char_reg),
        .state (line_state)
    );

    obd_rd_value u_value (
        .state (line_state),
        .ok    (res_ok),
        .qty   (res_qty),
        .val   (res_val)
    );

    assign emit     = in_valid_reg && is_term(rx_char_reg) && res_ok;
    // hold a result-bearing request while the result register is still occupied
    assign adv      = in_valid_reg && (!emit || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || adv;

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        rx_char_next   = rx_char_reg;
        out_valid_next = out_valid_reg;
        quantity_next  = quantity_reg;
        value_next     = value_reg;

        if (in_valid && in_ready)
        begin
            in_valid_next = 1'b1;
            rx_char_next  = rx_char;
        end
        else if (adv)
        begin
            in_valid_next = 1'b0;
        end

        if (adv && emit)
        begin
            out_valid_next = 1'b1;
            quantity_next  = res_qty;
            value_next     = res_val;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rx_char_reg  <= rx_char_next;
        quantity_reg <= quantity_next;
        value_reg    <= value_next;
    end

    assign out_valid = out_valid_reg;
    assign quantity  = quantity_reg;
    assign value     = value_reg;

    `OBD_RD_ASSERT_IMP(a_rise_only_on_term, clk, rst_n, $rose(out_valid_reg), $past(adv && is_term(rx_char_reg)))
    `OBD_RD_ASSERT_NEXT(a_stall_holds_char, clk, rst_n, in_valid_reg && !adv, in_valid_reg && $stable(rx_char_reg))
    `OBD_RD_ASSERT_IMP(a_qty_range, clk, rst_n, out_valid_reg, quantity_reg <= QTY_VOLTS)
    `OBD_RD_ASSERT_IMP(a_volts_range, clk, rst_n, out_valid_reg && (quantity_reg == QTY_VOLTS), (value_reg >= 22'sd0) && (value_reg <= 22'sd9999))

endmodule

// ===== dv/obd_rd_value_checker.sv =====
// Checker: follows both channels, predicts each decoded value and compares it.
module obd_rd_value_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  rx_char,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [2:0]  quantity,
    input  logic [21:0] value,
    output int          fail_count,
    output int          outstanding,
    output int          chars_taken,
    output int          values_checked,
    output logic [5:0]  qty_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    import obd_rd_pkg::*;

    typedef struct packed {
        quantity_t   qty;
        logic [21:0] val;
    } decoded_t;

    decoded_t decoded_q[$];

    // Line being parsed
    logic [3:0]  line_pos;
    line_kind_t  line_class;
    logic [7:0]  line_pid;
    logic [7:0]  line_a;
    logic [7:0]  line_b;
    logic [13:0] line_volt;
    logic [1:0]  line_frac;
    logic        line_bad;

    function automatic int nibble_of(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE)
            return int'(c - CH_ZERO);
        if (c >= CH_UA && c <= CH_UF)
            return int'(c - CH_UA) + 10;
        if (c >= CH_LA && c <= CH_LF_HEX)
            return int'(c - CH_LA) + 10;
        return -1;
    endfunction

    function automatic void clear_line();
        line_pos   = 4'd0;
        line_class = KIND_EMPTY;
        line_pid   = 8'd0;
        line_a     = 8'd0;
        line_b     = 8'd0;
        line_volt  = 14'd0;
        line_frac  = 2'd0;
        line_bad   = 1'b0;
    endfunction

    function automatic void push_volt_digit(input int d);
        int v;
        v = int'(line_volt) * 10 + d;
        line_volt = (v > int'(VOLT_MAX)) ? VOLT_MAX : 14'(v);
    endfunction

    function automatic void absorb_char(input logic [7:0] c);
        logic       pid_ok;
        line_kind_t volt_kind;
        logic       digit;
        int         h;
        pid_ok    = 1'b0;
        volt_kind = KIND_EMPTY;
        digit     = (c >= CH_ZERO) && (c <= CH_NINE);
        if (line_class == KIND_EMPTY || line_class == KIND_PID_DEC || line_class == KIND_PID)
        begin
            if (line_pos >= 4'd8)
                pid_ok = 1'b1;
            else if (line_pos == 4'd0)
                pid_ok = (c == CH_FOUR);
            else if (line_pos == 4'd1)
                pid_ok = (c == CH_ONE);
            else
            begin
                h = nibble_of(c);
                if (h >= 0)
                begin
                    pid_ok = 1'b1;
                    case (line_pos)
                        4'd2:    line_pid = {h[3:0], 4'h0};
                        4'd3:    line_pid = line_pid | {4'h0, h[3:0]};
                        4'd4:    line_a   = {h[3:0], 4'h0};
                        4'd5:    line_a   = line_a | {4'h0, h[3:0]};
                        4'd6:    line_b   = {h[3:0], 4'h0};
                        default: line_b   = line_b | {4'h0, h[3:0]};
                    endcase
                end
            end
        end
        if (line_class == KIND_EMPTY || line_class == KIND_PID_DEC
            || line_class == KIND_DEC || line_class == KIND_FRAC)
        begin
            if (digit)
            begin
                if (line_class == KIND_FRAC)
                begin
                    // keep two fraction digits, drop the rest
                    if (line_frac < 2'd2)
                    begin
                        push_volt_digit(int'(c - CH_ZERO));
                        line_frac = line_frac + 2'd1;
                    end
                    volt_kind = KIND_FRAC;
                end
                else
                begin
                    push_volt_digit(int'(c - CH_ZERO));
                    volt_kind = KIND_DEC;
                end
            end
            else if (c == CH_DOT && line_class != KIND_FRAC)
                volt_kind = KIND_FRAC;
            else if (c == CH_V && (line_class == KIND_PID_DEC || line_class == KIND_DEC
                     || (line_class == KIND_FRAC && line_pos >= 4'd2)))
                volt_kind = KIND_VOLTS;
        end
        if (pid_ok && volt_kind == KIND_DEC)
            line_class = KIND_PID_DEC;
        else if (pid_ok)
            line_class = KIND_PID;
        else if (volt_kind != KIND_EMPTY)
            line_class = volt_kind;
        else
            line_bad = 1'b1;
    endfunction

    function automatic logic close_line(output decoded_t res);
        int a;
        int b;
        int scaled;
        a   = int'(line_a);
        b   = int'(line_b);
        res = '{qty: QTY_COOLANT, val: '0};
        if (line_bad || line_pos == 4'd0)
            return 1'b0;
        if (line_class == KIND_VOLTS)
        begin
            scaled = int'(line_volt) * ((line_frac == 2'd0) ? 100 : (line_frac == 2'd1) ? 10 : 1);
            res.qty = QTY_VOLTS;
            res.val = 22'((scaled > int'(VOLT_MAX)) ? int'(VOLT_MAX) : scaled);
            return 1'b1;
        end
        if (!((line_class == KIND_PID_DEC || line_class == KIND_PID) && line_pos >= 4'd6))
            return 1'b0;
        case (line_pid)
            PID_COOLANT:
            begin
                res.qty = QTY_COOLANT;
                res.val = 22'((a - 40) * 100);
            end
            PID_INTAKE:
            begin
                res.qty = QTY_INTAKE;
                res.val = 22'((a - 40) * 100);
            end
            PID_LOAD:
            begin
                res.qty = QTY_LOAD;
                res.val = 22'(a * 10000 / 255);
            end
            PID_RPM:
            begin
                if (line_pos < 4'd8)
                    return 1'b0;
                res.qty = QTY_RPM;
                res.val = 22'(((a * 256 + b) / 4) * 100);
            end
            PID_MAF:
            begin
                if (line_pos < 4'd8)
                    return 1'b0;
                res.qty = QTY_MAF;
                res.val = 22'(a * 256 + b);
            end
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    always @(posedge clk)
    begin : track
        decoded_t want;
        if (!rst_n)
        begin
            clear_line();
            decoded_q.delete();
            qty_seen = '0;
        end
        else
        begin
            // results first: a request taken at this edge cannot have produced one yet
            if (out_valid && out_ready)
            begin
                if (decoded_q.size() == 0)
                begin
                    $display("%0t: unexpected value, quantity %0d value %0d",
                             $time, quantity, $signed(value));
                    fail_count++;
                end
                else
                begin
                    want = decoded_q.pop_front();
                    if (quantity !== want.qty)
                    begin
                        $display("%0t: quantity mismatch, expected %0d actual %0d",
                                 $time, want.qty, quantity);
                        fail_count++;
                    end
                    if (value !== want.val)
                    begin
                        $display("%0t: value mismatch (quantity %0d), expected %0d actual %0d",
                                 $time, want.qty, $signed(want.val), $signed(value));
                        fail_count++;
                    end
                    values_checked++;
                    if (quantity <= 3'd5)
                        qty_seen[quantity] = 1'b1;
                end
            end
            if (in_valid && in_ready)
            begin
                chars_taken++;
                if (rx_char == CH_CR || rx_char == CH_PROMPT)
                begin
                    if (close_line(want))
                        decoded_q.push_back(want);
                    clear_line();
                end
                else if (rx_char != CH_SPACE && rx_char != CH_LF)
                begin
                    if (!line_bad)
                        absorb_char(rx_char);
                    if (line_pos < 4'd15)
                        line_pos = line_pos + 4'd1;
                end
            end
        end
        outstanding = decoded_q.size();
    end

endmodule

// ===== dv/tb_obd_response_decoder_core.sv =====
// Testbench top: feeds adapter response text to the decoder and reports the verdict.
module tb_obd_response_decoder_core;
    timeunit 1ns;
    timeprecision 1ps;

    import obd_rd_pkg::*;

    localparam int RANDOM_CHARS    = 140;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 8;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    logic [7:0]         rx_char   = 8'h00;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [2:0]         quantity;
    logic signed [21:0] value;

    int         fail_count;
    int         outstanding;
    int         chars_taken;
    int         values_checked;
    logic [5:0] qty_seen;

    logic hold_off_req    = 1'b0;
    logic hold_off_active = 1'b0;
    logic gaps_on         = 1'b1;
    logic [7:0] char_fifo[$];

    obd_response_decoder_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_char   (rx_char),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .quantity  (quantity),
        .value     (value)
    );

    obd_rd_value_checker value_chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rx_char        (rx_char),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .quantity       (quantity),
        .value          (value),
        .fail_count     (fail_count),
        .outstanding    (outstanding),
        .chars_taken    (chars_taken),
        .values_checked (values_checked),
        .qty_seen       (qty_seen)
    );

    always #4 clk = ~clk;

    initial
    begin : time_limit
        #2000000;
        $display("obd_response_decoder_core verification failed");
        $finish;
    end

    function automatic logic [7:0] hex_char(input logic [3:0] n, input logic lower);
        if (n < 4'd10)
            return CH_ZERO + {4'h0, n};
        return (lower ? CH_LA : CH_UA) + {4'h0, n - 4'd10};
    endfunction

    function automatic void put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            char_fifo.push_back(s[i]);
    endfunction

    function automatic void end_line(input logic [7:0] t);
        char_fifo.push_back(t);
    endfunction

    function automatic void put_hex_byte(input logic [7:0] b);
        char_fifo.push_back(hex_char(b[7:4], $urandom_range(0, 1) == 1));
        char_fifo.push_back(hex_char(b[3:0], $urandom_range(0, 1) == 1));
    endfunction

    function automatic void put_sep();
        int r;
        r = $urandom_range(0, 19);
        if (r < 13)
            char_fifo.push_back(CH_SPACE);
        else if (r == 13)
            char_fifo.push_back(CH_LF);
    endfunction

    function automatic void put_term();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
        begin
            char_fifo.push_back(CH_CR);
            if (r < 2)
                char_fifo.push_back(CH_LF);
        end
        else
            char_fifo.push_back(CH_PROMPT);
    endfunction

    function automatic void put_pid_line(input logic [7:0] pid, input int nbytes, input int extra);
        put_text("41");
        put_sep();
        put_hex_byte(pid);
        for (int i = 0; i < nbytes; i++)
        begin
            put_sep();
            put_hex_byte(8'($urandom_range(0, 255)));
        end
        for (int i = 0; i < extra; i++)
            char_fifo.push_back(hex_char(4'($urandom_range(0, 15)), $urandom_range(0, 1) == 1));
    endfunction

    function automatic void put_random_line();
        logic [7:0] known [5];
        logic [7:0] pid;
        int         r;
        int         s;
        int         need;
        int         start;
        int         idx;
        known = '{PID_COOLANT, PID_INTAKE, PID_RPM, PID_LOAD, PID_MAF};
        pid   = known[$urandom_range(0, 4)];
        need  = (pid == PID_RPM || pid == PID_MAF) ? 2 : 1;
        r     = $urandom_range(0, 99);
        if (r < 50)
        begin
            s = $urandom_range(0, 9);
            if (s == 0)
                put_pid_line(pid, $urandom_range(0, need - 1), 0);
            else if (s == 1)
                put_pid_line(pid, need, $urandom_range(1, 6));
            else
                put_pid_line(pid, need, 0);
        end
        else if (r < 65)
        begin
            repeat ($urandom_range(0, 5))
                char_fifo.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
            if ($urandom_range(0, 1) == 1)
            begin
                char_fifo.push_back(CH_DOT);
                repeat ($urandom_range(0, 4))
                    char_fifo.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
            end
            char_fifo.push_back(CH_V);
            if ($urandom_range(0, 9) == 0)
                char_fifo.push_back(8'($urandom_range(0, 255)));
        end
        else if (r < 72)
            put_pid_line(8'($urandom_range(0, 255)), $urandom_range(0, 3), 0);
        else if (r < 85)
        begin
            // corrupt one character of an otherwise good line
            start = char_fifo.size();
            put_pid_line(pid, need, 0);
            idx = $urandom_range(start, char_fifo.size() - 1);
            char_fifo[idx] = 8'($urandom_range(0, 255));
        end
        else
        begin
            repeat ($urandom_range(1, 12))
                char_fifo.push_back(8'($urandom_range(0, 255)));
        end
        put_term();
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_fifo();
        int gap;
        while (char_fifo.size() > 0)
        begin
            in_valid <= 1'b1;
            rx_char  <= char_fifo.pop_front();
            do
                @(posedge clk);
            while (!in_ready);
            gap = gaps_on ? idle_len() : 0;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    initial
    begin : result_sink
        int r;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_off_req && !hold_off_active)
            begin
                // hold off long enough for the block to back up into its input
                hold_off_active = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 50)
                begin
                    out_ready <= 1'b1;
                    repeat ($urandom_range(1, 20)) @(posedge clk);
                end
                else
                begin
                    out_ready <= 1'b0;
                    if (r < 90)
                        repeat ($urandom_range(1, 3)) @(posedge clk);
                    else if (r < 97)
                        repeat ($urandom_range(4, 12)) @(posedge clk);
                    else
                        repeat ($urandom_range(30, 60)) @(posedge clk);
                end
            end
        end
    end

    initial
    begin : stimulus
        int rand_count;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        put_text("41 05 00");             end_line(CH_CR);
        put_text("41 05 FF");             end_line(CH_PROMPT);
        put_text("410f7b");               end_line(CH_CR);
        put_text("41 0C FF FF");          end_line(CH_CR);
        put_text("41 0c 00 00");          end_line(CH_CR);
        put_text("41 04 FF");             end_line(CH_CR);
        put_text("41 04 01");             end_line(CH_CR);
        put_text("41 10 FF FF");          end_line(CH_CR);
        put_text("41 10 aB cD");          end_line(CH_CR);
        // rpm with one data byte only
        put_text("41 0C 12");             end_line(CH_CR);
        put_text("41 05");                end_line(CH_CR);
        put_text("41 0G 12");             end_line(CH_CR);
        put_text("41 05 7B 11 22 33 44"); end_line(CH_CR);
        put_text("41 0D 20");             end_line(CH_CR);
        // fits both forms: decode as coolant
        put_text("41051234V");            end_line(CH_CR);
        put_text(".V");                   end_line(CH_CR);
        put_text("12.6V");                end_line(CH_CR);
        put_text("12.345V");              end_line(CH_PROMPT);
        put_text("99999V");               end_line(CH_CR);
        put_text("0.V");                  end_line(CH_CR);
        put_text("4112V");                end_line(CH_CR);
        put_text("12.6VX");               end_line(CH_CR);
        end_line(CH_CR);
        end_line(CH_PROMPT);
        put_text("41 05 7B");
        char_fifo.push_back(8'h01);
        end_line(CH_CR);
        put_text("41 0F");
        char_fifo.push_back(8'hC8);
        end_line(CH_CR);
        put_text("41 0F 3C");
        char_fifo.push_back(CH_LF);
        end_line(CH_CR);
        send_fifo();

        // drain everything before the back-pressure burst
        in_valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        @(posedge clk);

        hold_off_req = 1'b1;
        wait (hold_off_active);
        gaps_on = 1'b0;
        repeat (8)
        begin
            put_pid_line(PID_RPM, 2, 0);
            end_line(CH_CR);
        end
        send_fifo();

        rand_count = 0;
        while (rand_count < RANDOM_CHARS)
        begin
            gaps_on = ($urandom_range(0, 3) != 0);
            put_random_line();
            rand_count += char_fifo.size();
            send_fifo();
        end

        in_valid <= 1'b0;
        @(posedge clk);
        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run: %0d characters taken, %0d decoded values checked, quantities seen %b",
                 chars_taken, values_checked, qty_seen);
        $display("Run: long result hold-off with input back-pressure, full drain mid-run");
        if (fail_count == 0 && outstanding == 0)
            $display("obd_response_decoder_core verification clean");
        else
            $display("obd_response_decoder_core verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/obd_rd_pkg.sv
sv/obd_rd_parse.sv
sv/obd_rd_value.sv
sv/obd_response_decoder_core.sv
dv/obd_rd_value_checker.sv
dv/tb_obd_response_decoder_core.sv
